// ===== src/ebaf_pkg.sv =====
// Types and codes shared by the eight-bit ALU with flags.
package ebaf_pkg;

   // ALU operation selected by bits 5:3 of a register or immediate opcode
   typedef enum logic [2:0] {
      ALU_ADD = 3'd0,
      ALU_ADC = 3'd1,
      ALU_SUB = 3'd2,
      ALU_SBC = 3'd3,
      ALU_AND = 3'd4,
      ALU_XOR = 3'd5,
      ALU_OR  = 3'd6,
      ALU_CP  = 3'd7
   } alu_sel_type;

   // Accumulator and flag operation selected by bits 4:3 of 0x27/0x2F/0x37/0x3F
   typedef enum logic [1:0] {
      MISC_DAA = 2'd0,
      MISC_CPL = 2'd1,
      MISC_SCF = 2'd2,
      MISC_CCF = 2'd3
   } misc_sel_type;

   // Flag bit positions
   localparam int unsigned FLAG_Z = 3;
   localparam int unsigned FLAG_N = 2;
   localparam int unsigned FLAG_H = 1;
   localparam int unsigned FLAG_C = 0;

   // Decimal adjust constants
   localparam logic [7:0] DAA_HIGH_ADJ = 8'h60;
   localparam logic [7:0] DAA_LOW_ADJ  = 8'h06;
   localparam logic [7:0] DAA_HIGH_MAX = 8'h99;
   localparam logic [3:0] DAA_LOW_MAX  = 4'h9;

   // Program counter steps
   localparam logic [1:0] PC_STEP_NONE = 2'd0;
   localparam logic [1:0] PC_STEP_ONE  = 2'd1;
   localparam logic [1:0] PC_STEP_IMM  = 2'd2;

   // One input item, lowest field in the lowest bits
   typedef struct packed {
      logic [7:0] operand;
      logic [3:0] flags_in;
      logic [7:0] acc_in;
      logic [7:0] op;
   } req_item_type;

   // One result item, lowest field in the lowest bits
   typedef struct packed {
      logic       handled;
      logic [1:0] pc_step;
      logic [3:0] flags_out;
      logic       write_to_acc;
      logic       write_enable;
      logic [7:0] result;
   } rsp_item_type;

endpackage

// ===== src/eight_bit_alu_with_flags_unit.sv =====
// Top level of the eight-bit ALU with flags: input register, ALU, result register.
//
//   channel | dir | width | transfer carries
//   --------+-----+-------+-----------------------------------------------
//   req_    | in  |  32   | op, acc_in, flags_in, operand
//   rsp_    | out |  24   | result, write_enable, write_to_acc, flags_out,
//           |     |       | pc_step, handled
//
// One item per cycle sustained while rsp_tready stays high. A req transfer is
// registered first in the input register, then in the result register around the
// ALU, before rsp_tvalid rises and the rsp transfer can take place.
// Synchronous active-high reset clears both valid bits; payload registers are
// not reset. A stall on rsp_ holds the result register and backs up into the
// input register, and req_tready drops only when both registers are full.
module eight_bit_alu_with_flags_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // op[7:0], acc_in[15:8], flags_in[19:16], operand[27:20], zeros[31:28]
   input  logic [31:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // result[7:0], write_enable[8], write_to_acc[9], flags_out[13:10],
   // pc_step[15:14], handled[16], zeros[23:17]
   output logic [23:0] rsp_tdata
);

   ebaf_pkg::req_item_type req_item_ff, req_item_in;
   ebaf_pkg::rsp_item_type rsp_item_ff, rsp_item_in;
   ebaf_pkg::rsp_item_type alu_item;
   logic in_valid_ff, in_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_ready;
   logic req_xfer;

   // The result register frees up when empty or when its transfer completes;
   // the input register advances whenever the result register can take it.
   assign out_ready  = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || out_ready;
   assign req_xfer   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      req_item_in = req_item_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
      if (req_xfer) begin
         req_item_in = ebaf_pkg::req_item_type'(req_tdata[27:0]);
      end
   end

   ebaf_alu u_alu (
      .req_item (req_item_ff),
      .rsp_item (alu_item)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (out_ready) begin
         rsp_valid_in = in_valid_ff;
         if (in_valid_ff) begin
            rsp_item_in = alu_item;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_item_ff <= req_item_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_item_ff};

`ifndef SYNTHESIS
   // An accepted request always lands in the input register
   a_req_lands: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> in_valid_ff)
      else $error("accepted request lost");

   // A waiting item in the input register is never dropped during a stall
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_ready) |=> in_valid_ff)
      else $error("stalled item dropped");

   // A filled input register always produces a result next cycle when free
   a_in_to_out: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_ready) |=> rsp_valid_ff)
      else $error("result not produced");

   // Unhandled opcodes write nothing and do not step the program counter
   a_unhandled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_item_ff.handled) |->
         (rsp_item_ff.pc_step == ebaf_pkg::PC_STEP_NONE) && !rsp_item_ff.write_enable)
      else $error("unhandled opcode has side effects");

   // Whenever nothing is written the result value is zero
   a_no_write_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_item_ff.write_enable) |->
         (rsp_item_ff.result == 8'd0) && !rsp_item_ff.write_to_acc)
      else $error("nonzero result without write");
`endif

endmodule

// ===== src/ebaf_alu.sv =====
// Combinational decode and compute of one ALU instruction.
module ebaf_alu (
   input  ebaf_pkg::req_item_type req_item,
   output ebaf_pkg::rsp_item_type rsp_item
);

   logic [7:0] op;
   logic [7:0] a;
   logic [7:0] v;
   logic [3:0] f;
   logic       c;

   logic                  is_incdec;
   logic                  is_alu;
   logic                  is_misc;
   ebaf_pkg::alu_sel_type  alu_sel;
   ebaf_pkg::misc_sel_type misc_sel;

   logic       cin;
   logic [8:0] sum9;
   logic [4:0] hsum5;
   logic [8:0] diff9;
   logic [4:0] hdiff5;
   logic [7:0] inc8;
   logic [7:0] dec8;
   logic       daa_big;
   logic       daa_small;
   logic [7:0] daa_mid;
   logic [7:0] daa_res;

   assign op = req_item.op;
   assign a  = req_item.acc_in;
   assign v  = req_item.operand;
   assign f  = req_item.flags_in;
   assign c  = f[ebaf_pkg::FLAG_C];

   assign is_incdec = (op[7:6] == 2'b00) && (op[2:1] == 2'b10);
   assign is_alu    = (op[7:6] == 2'b10) || ((op[7:6] == 2'b11) && (op[2:0] == 3'b110));
   assign is_misc   = (op[7:5] == 3'b001) && (op[2:0] == 3'b111);
   assign alu_sel   = ebaf_pkg::alu_sel_type'(op[5:3]);
   assign misc_sel  = ebaf_pkg::misc_sel_type'(op[4:3]);

   // Carry in only for ADC and SBC
   assign cin    = ((alu_sel == ebaf_pkg::ALU_ADC) || (alu_sel == ebaf_pkg::ALU_SBC)) ? c : 1'b0;
   assign sum9   = {1'b0, a} + {1'b0, v} + {8'd0, cin};
   assign hsum5  = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, cin};
   assign diff9  = {1'b0, a} - {1'b0, v} - {8'd0, cin};
   assign hdiff5 = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, cin};
   assign inc8   = v + 8'd1;
   assign dec8   = v - 8'd1;

   // Decimal adjust: subtract path after N, add path otherwise
   assign daa_big   = c || (a > ebaf_pkg::DAA_HIGH_MAX);
   assign daa_small = f[ebaf_pkg::FLAG_H] || (a[3:0] > ebaf_pkg::DAA_LOW_MAX);
   always_comb begin
      if (f[ebaf_pkg::FLAG_N]) begin
         daa_mid = a - (c ? ebaf_pkg::DAA_HIGH_ADJ : 8'd0);
         daa_res = daa_mid - (f[ebaf_pkg::FLAG_H] ? ebaf_pkg::DAA_LOW_ADJ : 8'd0);
      end else begin
         daa_mid = a + (daa_big ? ebaf_pkg::DAA_HIGH_ADJ : 8'd0);
         daa_res = daa_mid + (daa_small ? ebaf_pkg::DAA_LOW_ADJ : 8'd0);
      end
   end

   always_comb begin
      rsp_item = '0;
      if (is_incdec) begin
         rsp_item.handled      = 1'b1;
         rsp_item.pc_step      = ebaf_pkg::PC_STEP_ONE;
         rsp_item.write_enable = 1'b1;
         rsp_item.flags_out[ebaf_pkg::FLAG_C] = c;
         if (op[0]) begin
            rsp_item.result = dec8;
            rsp_item.flags_out[ebaf_pkg::FLAG_N] = 1'b1;
            rsp_item.flags_out[ebaf_pkg::FLAG_H] = (v[3:0] == 4'h0);
         end else begin
            rsp_item.result = inc8;
            rsp_item.flags_out[ebaf_pkg::FLAG_H] = (v[3:0] == 4'hF);
         end
         rsp_item.flags_out[ebaf_pkg::FLAG_Z] = (rsp_item.result == 8'd0);
      end else if (is_alu) begin
         rsp_item.handled      = 1'b1;
         rsp_item.pc_step      = op[6] ? ebaf_pkg::PC_STEP_IMM : ebaf_pkg::PC_STEP_ONE;
         rsp_item.write_enable = 1'b1;
         rsp_item.write_to_acc = 1'b1;
         unique case (alu_sel)
            ebaf_pkg::ALU_ADD, ebaf_pkg::ALU_ADC: begin
               rsp_item.result = sum9[7:0];
               rsp_item.flags_out[ebaf_pkg::FLAG_H] = hsum5[4];
               rsp_item.flags_out[ebaf_pkg::FLAG_C] = sum9[8];
               rsp_item.flags_out[ebaf_pkg::FLAG_Z] = (sum9[7:0] == 8'd0);
            end
            ebaf_pkg::ALU_SUB, ebaf_pkg::ALU_SBC: begin
               rsp_item.result = diff9[7:0];
               rsp_item.flags_out[ebaf_pkg::FLAG_N] = 1'b1;
               rsp_item.flags_out[ebaf_pkg::FLAG_H] = hdiff5[4];
               rsp_item.flags_out[ebaf_pkg::FLAG_C] = diff9[8];
               rsp_item.flags_out[ebaf_pkg::FLAG_Z] = (diff9[7:0] == 8'd0);
            end
            ebaf_pkg::ALU_CP: begin
               // Compare: flags only, nothing written
               rsp_item.write_enable = 1'b0;
               rsp_item.write_to_acc = 1'b0;
               rsp_item.flags_out[ebaf_pkg::FLAG_N] = 1'b1;
               rsp_item.flags_out[ebaf_pkg::FLAG_H] = hdiff5[4];
               rsp_item.flags_out[ebaf_pkg::FLAG_C] = diff9[8];
               rsp_item.flags_out[ebaf_pkg::FLAG_Z] = (diff9[7:0] == 8'd0);
            end
            ebaf_pkg::ALU_AND: begin
               rsp_item.result = a & v;
               rsp_item.flags_out[ebaf_pkg::FLAG_H] = 1'b1;
               rsp_item.flags_out[ebaf_pkg::FLAG_Z] = ((a & v) == 8'd0);
            end
            ebaf_pkg::ALU_XOR: begin
               rsp_item.result = a ^ v;
               rsp_item.flags_out[ebaf_pkg::FLAG_Z] = ((a ^ v) == 8'd0);
            end
            ebaf_pkg::ALU_OR: begin
               rsp_item.result = a | v;
               rsp_item.flags_out[ebaf_pkg::FLAG_Z] = ((a | v) == 8'd0);
            end
         endcase
      end else if (is_misc) begin
         rsp_item.handled = 1'b1;
         rsp_item.pc_step = ebaf_pkg::PC_STEP_ONE;
         unique case (misc_sel)
            ebaf_pkg::MISC_DAA: begin
               rsp_item.result       = daa_res;
               rsp_item.write_enable = 1'b1;
               rsp_item.write_to_acc = 1'b1;
               rsp_item.flags_out[ebaf_pkg::FLAG_N] = f[ebaf_pkg::FLAG_N];
               rsp_item.flags_out[ebaf_pkg::FLAG_C] =
                  c || (!f[ebaf_pkg::FLAG_N] && daa_big);
               rsp_item.flags_out[ebaf_pkg::FLAG_Z] = (daa_res == 8'd0);
            end
            ebaf_pkg::MISC_CPL: begin
               rsp_item.result       = ~a;
               rsp_item.write_enable = 1'b1;
               rsp_item.write_to_acc = 1'b1;
               rsp_item.flags_out = {f[ebaf_pkg::FLAG_Z], 1'b1, 1'b1, c};
            end
            ebaf_pkg::MISC_SCF: begin
               rsp_item.flags_out = {f[ebaf_pkg::FLAG_Z], 1'b0, 1'b0, 1'b1};
            end
            ebaf_pkg::MISC_CCF: begin
               rsp_item.flags_out = {f[ebaf_pkg::FLAG_Z], 1'b0, 1'b0, ~c};
            end
         endcase
      end
   end

endmodule

// ===== tb/tb_eight_bit_alu_with_flags_unit.sv =====
// Self-checking testbench for the eight-bit ALU with flags.
`timescale 1ns / 100ps

module tb_eight_bit_alu_with_flags_unit;

   // Opcode decode patterns, matched as (op & MASK) == CODE
   localparam logic [7:0] INCDEC_MASK = 8'hC6;
   localparam logic [7:0] INCDEC_CODE = 8'h04;
   localparam logic [7:0] GROUP_MASK  = 8'hC0;
   localparam logic [7:0] REG_GROUP   = 8'h80;
   localparam logic [7:0] IMM_MASK    = 8'hC7;
   localparam logic [7:0] IMM_CODE    = 8'hC6;
   localparam logic [7:0] MISC_MASK   = 8'hE7;
   localparam logic [7:0] MISC_CODE   = 8'h27;

   // Source register fields
   localparam logic [2:0] REG_B  = 3'd0;
   localparam logic [2:0] REG_E  = 3'd3;
   localparam logic [2:0] REG_HL = 3'd6;
   localparam logic [2:0] REG_A  = 3'd7;

   // Opcodes outside the ALU group
   localparam logic [7:0] OP_NOP  = 8'h00;
   localparam logic [7:0] OP_HALT = 8'h76;
   localparam logic [7:0] OP_RST  = 8'hFF;

   localparam int unsigned MAX_REPORTS = 10;
   localparam int unsigned RANDOM_ITEMS = 450;
   localparam int unsigned SETTLE_CYCLES = 8;

   // Receiver stall patterns
   typedef enum logic [1:0] {
      RX_OPEN,
      RX_SPARSE_STALL,
      RX_DUTY,
      RX_STARVED
   } rx_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;

   // Expected results in issue order, oldest at the front
   ebaf_pkg::rsp_item_type expected_rsp[$];
   int unsigned  fail_count = 0;
   int unsigned  burst_left = 0;

   rx_mode_type  rx_mode = RX_OPEN;
   logic [7:0]   rx_tick = '0;
   ebaf_pkg::rsp_item_type seen_rsp;
   ebaf_pkg::rsp_item_type want_rsp;

   eight_bit_alu_with_flags_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      // op[7:0], acc_in[15:8], flags_in[19:16], operand[27:20], zeros[31:28]
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      // result[7:0], write_enable[8], write_to_acc[9], flags_out[13:10],
      // pc_step[15:14], handled[16], zeros[23:17]
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   // Opcode builders
   function automatic logic [7:0] incdec_op(input logic [2:0] reg_sel, input logic is_dec);
      return {2'b00, reg_sel, 2'b10, is_dec};
   endfunction

   function automatic logic [7:0] reg_op(input ebaf_pkg::alu_sel_type sel,
                                         input logic [2:0] reg_sel);
      return {2'b10, sel, reg_sel};
   endfunction

   function automatic logic [7:0] imm_op(input ebaf_pkg::alu_sel_type sel);
      return {2'b11, sel, 3'b110};
   endfunction

   function automatic logic [7:0] misc_op(input ebaf_pkg::misc_sel_type kind);
      return {3'b001, kind, 3'b111};
   endfunction

   // Compute the full result of one instruction from its own inputs
   function automatic ebaf_pkg::rsp_item_type alu_outcome(input ebaf_pkg::req_item_type it);
      ebaf_pkg::rsp_item_type o;
      ebaf_pkg::alu_sel_type  sel;
      ebaf_pkg::misc_sel_type kind;
      logic [7:0]   r;
      logic [8:0]   wide;
      logic [4:0]   nib;
      logic         cin;
      logic [3:0]   f;

      o = '0;
      f = it.flags_in;
      r = '0;
      if ((it.op & INCDEC_MASK) == INCDEC_CODE) begin
         // INC/DEC keep carry and write back to the source register
         o.flags_out[ebaf_pkg::FLAG_C] = f[ebaf_pkg::FLAG_C];
         if (it.op[0]) begin
            r = it.operand - 8'd1;
            o.flags_out[ebaf_pkg::FLAG_N] = 1'b1;
            o.flags_out[ebaf_pkg::FLAG_H] = (it.operand[3:0] == 4'h0);
         end else begin
            r = it.operand + 8'd1;
            o.flags_out[ebaf_pkg::FLAG_H] = (it.operand[3:0] == 4'hF);
         end
         o.flags_out[ebaf_pkg::FLAG_Z] = (r == 8'h00);
         o.result       = r;
         o.write_enable = 1'b1;
         o.write_to_acc = 1'b0;
         o.pc_step      = ebaf_pkg::PC_STEP_ONE;
         o.handled      = 1'b1;
      end else if ((it.op & GROUP_MASK) == REG_GROUP || (it.op & IMM_MASK) == IMM_CODE) begin
         sel = ebaf_pkg::alu_sel_type'(it.op[5:3]);
         o.write_enable = 1'b1;
         case (sel)
            ebaf_pkg::ALU_ADD, ebaf_pkg::ALU_ADC: begin
               cin  = (sel == ebaf_pkg::ALU_ADC) & f[ebaf_pkg::FLAG_C];
               wide = {1'b0, it.acc_in} + {1'b0, it.operand} + {8'd0, cin};
               nib  = {1'b0, it.acc_in[3:0]} + {1'b0, it.operand[3:0]} + {4'd0, cin};
               r    = wide[7:0];
               o.flags_out[ebaf_pkg::FLAG_H] = nib[4];
               o.flags_out[ebaf_pkg::FLAG_C] = wide[8];
            end
            ebaf_pkg::ALU_SUB, ebaf_pkg::ALU_SBC, ebaf_pkg::ALU_CP: begin
               // borrow shows up as the sign bit of the widened difference
               cin  = (sel == ebaf_pkg::ALU_SBC) & f[ebaf_pkg::FLAG_C];
               wide = {1'b0, it.acc_in} - {1'b0, it.operand} - {8'd0, cin};
               nib  = {1'b0, it.acc_in[3:0]} - {1'b0, it.operand[3:0]} - {4'd0, cin};
               r    = wide[7:0];
               o.flags_out[ebaf_pkg::FLAG_N] = 1'b1;
               o.flags_out[ebaf_pkg::FLAG_H] = nib[4];
               o.flags_out[ebaf_pkg::FLAG_C] = wide[8];
               if (sel == ebaf_pkg::ALU_CP) o.write_enable = 1'b0;
            end
            ebaf_pkg::ALU_AND: begin
               r = it.acc_in & it.operand;
               o.flags_out[ebaf_pkg::FLAG_H] = 1'b1;
            end
            ebaf_pkg::ALU_XOR: r = it.acc_in ^ it.operand;
            default: r = it.acc_in | it.operand;
         endcase
         // compare still sets Z from the discarded difference
         o.flags_out[ebaf_pkg::FLAG_Z] = (r == 8'h00);
         o.result       = o.write_enable ? r : 8'h00;
         o.write_to_acc = o.write_enable;
         o.pc_step      = (it.op[7:6] == 2'b11) ? ebaf_pkg::PC_STEP_IMM : ebaf_pkg::PC_STEP_ONE;
         o.handled      = 1'b1;
      end else if ((it.op & MISC_MASK) == MISC_CODE) begin
         kind = ebaf_pkg::misc_sel_type'(it.op[4:3]);
         o.handled = 1'b1;
         o.pc_step = ebaf_pkg::PC_STEP_ONE;
         case (kind)
            ebaf_pkg::MISC_DAA: begin
               r = it.acc_in;
               o.flags_out[ebaf_pkg::FLAG_N] = f[ebaf_pkg::FLAG_N];
               o.flags_out[ebaf_pkg::FLAG_C] = f[ebaf_pkg::FLAG_C];
               if (f[ebaf_pkg::FLAG_N]) begin
                  if (f[ebaf_pkg::FLAG_C]) r = r - ebaf_pkg::DAA_HIGH_ADJ;
                  if (f[ebaf_pkg::FLAG_H]) r = r - ebaf_pkg::DAA_LOW_ADJ;
               end else begin
                  if (f[ebaf_pkg::FLAG_C] || r > ebaf_pkg::DAA_HIGH_MAX) begin
                     r = r + ebaf_pkg::DAA_HIGH_ADJ;
                     o.flags_out[ebaf_pkg::FLAG_C] = 1'b1;
                  end
                  if (f[ebaf_pkg::FLAG_H] || r[3:0] > ebaf_pkg::DAA_LOW_MAX)
                     r = r + ebaf_pkg::DAA_LOW_ADJ;
               end
               o.flags_out[ebaf_pkg::FLAG_Z] = (r == 8'h00);
               o.result       = r;
               o.write_enable = 1'b1;
               o.write_to_acc = 1'b1;
            end
            ebaf_pkg::MISC_CPL: begin
               o.result = ~it.acc_in;
               o.flags_out[ebaf_pkg::FLAG_Z] = f[ebaf_pkg::FLAG_Z];
               o.flags_out[ebaf_pkg::FLAG_N] = 1'b1;
               o.flags_out[ebaf_pkg::FLAG_H] = 1'b1;
               o.flags_out[ebaf_pkg::FLAG_C] = f[ebaf_pkg::FLAG_C];
               o.write_enable = 1'b1;
               o.write_to_acc = 1'b1;
            end
            ebaf_pkg::MISC_SCF: begin
               o.flags_out[ebaf_pkg::FLAG_Z] = f[ebaf_pkg::FLAG_Z];
               o.flags_out[ebaf_pkg::FLAG_C] = 1'b1;
            end
            default: begin
               o.flags_out[ebaf_pkg::FLAG_Z] = f[ebaf_pkg::FLAG_Z];
               o.flags_out[ebaf_pkg::FLAG_C] = ~f[ebaf_pkg::FLAG_C];
            end
         endcase
      end
      return o;
   endfunction

   // Byte that lands on a boundary value about a third of the time
   function automatic logic [7:0] pick_byte();
      if ($urandom_range(0, 2) != 0) return 8'($urandom_range(0, 255));
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h0F;
         3: return 8'hF0;
         4: return 8'h99;
         5: return 8'h9A;
         6: return 8'h01;
         default: return 8'h80;
      endcase
   endfunction

   // Offer one instruction and hold it until the transfer; drop valid only
   // between bursts so gaps land on every pipeline phase
   task automatic send_item(input logic [7:0] op, input logic [7:0] acc,
                            input logic [3:0] flags, input logic [7:0] operand);
      ebaf_pkg::req_item_type it;

      it.op       = op;
      it.acc_in   = acc;
      it.flags_in = flags;
      it.operand  = operand;
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         // about one burst in four runs long with no idling at all
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 12);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0000, it};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_rsp.push_back(alu_outcome(it));
      burst_left--;
   endtask

   // Hold off the sender until every outstanding result has come back
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (expected_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic test_inc_dec();
      send_item(incdec_op(REG_B, 1'b0), 8'h00, 4'b0000, 8'hFF);
      send_item(incdec_op(REG_HL, 1'b0), 8'hFF, 4'b1111, 8'h0F);
      send_item(incdec_op(REG_A, 1'b1), 8'h00, 4'b0001, 8'h00);
      send_item(incdec_op(REG_E, 1'b1), 8'h55, 4'b1110, 8'h10);
      send_item(incdec_op(REG_HL, 1'b1), 8'hAA, 4'b0000, 8'h01);
   endtask

   task automatic test_alu_ops();
      send_item(reg_op(ebaf_pkg::ALU_ADD, REG_B), 8'hFF, 4'b0000, 8'h01);
      send_item(imm_op(ebaf_pkg::ALU_ADC), 8'h0F, 4'b0001, 8'h00);
      send_item(reg_op(ebaf_pkg::ALU_ADC, REG_HL), 8'hFF, 4'b0001, 8'h00);
      send_item(imm_op(ebaf_pkg::ALU_SUB), 8'h00, 4'b0000, 8'h01);
      send_item(reg_op(ebaf_pkg::ALU_SBC, REG_E), 8'h10, 4'b0001, 8'h00);
      send_item(imm_op(ebaf_pkg::ALU_SBC), 8'h00, 4'b0001, 8'hFF);
      send_item(reg_op(ebaf_pkg::ALU_AND, REG_A), 8'hF0, 4'b1111, 8'h0F);
      send_item(imm_op(ebaf_pkg::ALU_XOR), 8'hFF, 4'b0000, 8'hFF);
      send_item(reg_op(ebaf_pkg::ALU_OR, REG_B), 8'h00, 4'b1111, 8'h00);
      send_item(imm_op(ebaf_pkg::ALU_CP), 8'h42, 4'b0000, 8'h42);
   endtask

   task automatic test_misc_ops();
      send_item(misc_op(ebaf_pkg::MISC_DAA), 8'h9A, 4'b0000, 8'h00);
      send_item(misc_op(ebaf_pkg::MISC_DAA), 8'h00, 4'b0011, 8'hFF);
      send_item(misc_op(ebaf_pkg::MISC_DAA), 8'h00, 4'b0111, 8'h00);
      send_item(misc_op(ebaf_pkg::MISC_CPL), 8'h00, 4'b1111, 8'h00);
      send_item(misc_op(ebaf_pkg::MISC_SCF), 8'hFF, 4'b0000, 8'h00);
      send_item(misc_op(ebaf_pkg::MISC_CCF), 8'h00, 4'b1111, 8'h00);
      send_item(misc_op(ebaf_pkg::MISC_CCF), 8'h00, 4'b0000, 8'hFF);
   endtask

   task automatic test_unhandled();
      send_item(OP_NOP, 8'hFF, 4'b1111, 8'hFF);
      send_item(OP_HALT, 8'h00, 4'b0000, 8'h00);
      send_item(OP_RST, 8'h5A, 4'b1010, 8'hA5);
   endtask

   // Mostly decodable instructions with random operands, the rest raw bytes
   task automatic test_random_mix();
      logic [7:0] op;

      for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
         case ($urandom_range(0, 9))
            0, 1:    op = incdec_op(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
            2, 3, 4: op = reg_op(ebaf_pkg::alu_sel_type'($urandom_range(0, 7)),
                                 3'($urandom_range(0, 7)));
            5, 6:    op = imm_op(ebaf_pkg::alu_sel_type'($urandom_range(0, 7)));
            7:       op = misc_op(ebaf_pkg::misc_sel_type'($urandom_range(0, 3)));
            default: op = 8'($urandom_range(0, 255));
         endcase
         send_item(op, pick_byte(), 4'($urandom_range(0, 15)), pick_byte());
         if (i == RANDOM_ITEMS / 2) wait_for_drain();
      end
   endtask

   // Receiver readiness: a new pattern is drawn at random whenever rx_tick[5:0] wraps to zero
   always @(posedge clock) begin
      rx_tick <= rx_tick + 8'd1;
      if (rx_tick[5:0] == 6'd0) rx_mode <= rx_mode_type'($urandom_range(0, 3));
      case (rx_mode)
         RX_OPEN:         rsp_tready <= 1'b1;
         RX_SPARSE_STALL: rsp_tready <= ($urandom_range(0, 3) != 0);
         RX_DUTY:         rsp_tready <= (rx_tick[2:0] >= 3'd3);
         default:         rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // Match every result transfer against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_rsp = ebaf_pkg::rsp_item_type'(rsp_tdata[16:0]);
         if (expected_rsp.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("unexpected result transfer: %h", rsp_tdata);
         end else begin
            want_rsp = expected_rsp.pop_front();
            if (seen_rsp.result       !== want_rsp.result ||
                seen_rsp.write_enable !== want_rsp.write_enable ||
                seen_rsp.write_to_acc !== want_rsp.write_to_acc ||
                seen_rsp.flags_out    !== want_rsp.flags_out ||
                seen_rsp.pc_step      !== want_rsp.pc_step ||
                seen_rsp.handled      !== want_rsp.handled) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("mismatch: exp res=%h we=%b wta=%b fl=%b pc=%0d hd=%b",
                           want_rsp.result, want_rsp.write_enable, want_rsp.write_to_acc,
                           want_rsp.flags_out, want_rsp.pc_step, want_rsp.handled,
                           " / got res=%h we=%b wta=%b fl=%b pc=%0d hd=%b",
                           seen_rsp.result, seen_rsp.write_enable, seen_rsp.write_to_acc,
                           seen_rsp.flags_out, seen_rsp.pc_step, seen_rsp.handled);
            end
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_inc_dec();
      test_alu_ops();
      test_misc_ops();
      test_unhandled();
      wait_for_drain();
      test_random_mix();
      req_tvalid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      // let any stray result surface before the verdict
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_rsp.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Guard against a hung handshake
   initial begin
      #400000;
      $display("FAIL");
      $finish;
   end

endmodule
